[rtl/pli_pkg.sv]
// Shared definitions for the piecewise linear interpolation unit:
// opcodes, result kinds, field widths, sequencer states and datapath sizes.
// Depends on nothing; used by piecewise_linear_interp_unit.
package pli_pkg;

    localparam int PLI_MAX_POINTS = 16;

    localparam int COORD_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int KIND_W  = 2;

    // Widened difference, magnitude and remainder width (sign-extended coordinates).
    localparam int DIFF_W  = COORD_W + 1;
    // Partial remainder after doubling and adding dx can reach three times the divisor.
    localparam int PART_W  = DIFF_W + 2;
    // One step per bit of the multiplicand magnitude.
    localparam int MULDIV_STEPS = DIFF_W;
    localparam int STEP_W  = $clog2(MULDIV_STEPS + 1);

    localparam int S_TDATA_W = ((INDEX_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COORD_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = COUNT_W'(2);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAST   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_SEARCH,
        ST_MULDIV,
        ST_SUM,
        ST_DONE
    } pli_state_t;

endpackage

[rtl/piecewise_linear_interp_unit.sv]
// Top level of the piecewise linear interpolation unit: breakpoint table,
// search sequencer and bit-serial multiply-divide. Depends on pli_pkg and pli_ram.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: opcode; tdata: point_index, x, y
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: clamp_kind; tdata: y_result
//  cfg       in   cfg_we (no ready)              cfg_wdata: point_count
//
// A load transaction writes one table slot.
// A query reads the first and then the last breakpoint and posts a clamped result
// if it lies at or beyond either; otherwise it scans breakpoints 1 .. n-1, one table
// read per cycle, then runs the 33-step shift-and-subtract multiply-divide loop, one
// multiplicand bit per cycle. Only one transaction is in flight at a time.
// The result sits in an output register, so a new transaction is taken while it waits;
// a finished query holds in the last state only if that register is still occupied.
// Reset sets point_count to 2 and clears control; the table is undefined until loaded.
module piecewise_linear_interp_unit #(
    parameter int MAX_POINTS = pli_pkg::PLI_MAX_POINTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pli_pkg::S_TDATA_W-1:0] s_axis_tdata,  // point_index[3:0], x_coord[35:4],
                                                         // y_coord[67:36], zero pad
    input  logic                         s_axis_tuser,  // opcode
    // master side
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pli_pkg::M_TDATA_W-1:0] m_axis_tdata,  // y_result[31:0]
    output logic [pli_pkg::KIND_W-1:0]   m_axis_tuser,  // clamp_kind[1:0]
    // configuration
    input  logic                         cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]  cfg_wdata      // point_count
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = pli_pkg::COORD_W;
    localparam int DW = pli_pkg::DIFF_W;
    localparam int PW = pli_pkg::PART_W;
    localparam int SW = pli_pkg::STEP_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pli_pkg::pli_state_t state_reg, state_next;

    logic [pli_pkg::COUNT_W-1:0] pc_reg;
    logic [CW-1:0]               qx_reg,  qx_next;     // query x
    logic [AW:0]                 idx_reg, idx_next;    // address being read
    logic [CW-1:0]               px_reg,  px_next;     // previous breakpoint
    logic [CW-1:0]               py_reg,  py_next;
    logic [DW-1:0]               den_reg, den_next;
    logic [DW-1:0]               dx_reg,  dx_next;
    logic [DW-1:0]               mag_reg, mag_next;    // |dy|, shifted out MSB first
    logic                        neg_reg, neg_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               quo_reg, quo_next;
    logic [SW-1:0]               step_reg, step_next;
    logic [CW-1:0]               res_reg, res_next;
    logic [pli_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [CW-1:0]               out_y_reg, out_y_next;
    logic [pli_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic                        out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    logic [pli_pkg::INDEX_W-1:0] in_index;
    logic [CW-1:0]               in_x;
    logic [CW-1:0]               in_y;
    logic                        s_fire;

    assign in_index = s_axis_tdata[pli_pkg::INDEX_W-1:0];
    assign in_x     = s_axis_tdata[pli_pkg::INDEX_W +: CW];
    assign in_y     = s_axis_tdata[pli_pkg::INDEX_W + CW +: CW];

    assign s_axis_tready = (state_reg == pli_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Breakpoint table: {y, x} per slot; loads to slots past the table drop
    // ------------------------------------------------------------------
    logic            tbl_we;
    logic [AW-1:0]   tbl_raddr;
    logic [2*CW-1:0] tbl_rdata;
    logic [CW-1:0]   rd_x;
    logic [CW-1:0]   rd_y;

    assign tbl_we = s_fire && (s_axis_tuser == pli_pkg::OP_LOAD)
                    && ({28'd0, in_index} < 32'(MAX_POINTS));

    pli_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(in_index)),
        .wdata ({in_y, in_x}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign rd_x = tbl_rdata[CW-1:0];
    assign rd_y = tbl_rdata[2*CW-1:CW];

    // ------------------------------------------------------------------
    // Effective point count: zero acts as one, saturate at the table depth
    // ------------------------------------------------------------------
    logic [AW:0]   n_eff;
    logic [AW:0]   n_m1;
    logic [AW-1:0] last_idx;

    always_comb
    begin
        priority if (pc_reg == '0)
        begin
            n_eff = (AW+1)'(1);
        end
        else if ({27'd0, pc_reg} > 32'(MAX_POINTS))
        begin
            n_eff = (AW+1)'(MAX_POINTS);
        end
        else
        begin
            n_eff = (AW+1)'(pc_reg);
        end
    end

    assign n_m1     = n_eff - (AW+1)'(1);
    assign last_idx = n_m1[AW-1:0];

    // ------------------------------------------------------------------
    // Compares against the entry on the table read port
    // ------------------------------------------------------------------
    logic q_le_rd;
    logic q_ge_rd;

    assign q_le_rd = ($signed(qx_reg) <= $signed(rd_x));
    assign q_ge_rd = ($signed(qx_reg) >= $signed(rd_x));

    // Segment setup, computed when the search hits
    logic [DW-1:0] seg_den;
    logic [DW-1:0] seg_dx;
    logic          seg_neg;
    logic [DW-1:0] seg_up;
    logic [DW-1:0] seg_down;

    assign seg_den  = {rd_x[CW-1], rd_x} - {px_reg[CW-1], px_reg};
    assign seg_dx   = {qx_reg[CW-1], qx_reg} - {px_reg[CW-1], px_reg};
    assign seg_neg  = ($signed(rd_y) < $signed(py_reg));
    assign seg_up   = {rd_y[CW-1], rd_y} - {py_reg[CW-1], py_reg};
    assign seg_down = {py_reg[CW-1], py_reg} - {rd_y[CW-1], rd_y};

    // ------------------------------------------------------------------
    // One multiply-divide step: r = 2r + bit*dx, then take out up to 2*den
    // ------------------------------------------------------------------
    logic [PW-1:0]   part;
    logic [PW:0]     sub_one;
    logic [PW:0]     sub_two;
    logic [1:0]      digit;
    logic [PW-1:0]   part_rem;

    assign part    = {1'b0, rem_reg, 1'b0} + (mag_reg[DW-1] ? {2'b0, dx_reg} : '0);
    assign sub_one = {1'b0, part} - {3'b0, den_reg};
    assign sub_two = {1'b0, part} - {2'b0, den_reg, 1'b0};

    always_comb
    begin
        priority if (!sub_two[PW])
        begin
            digit    = 2'd2;
            part_rem = sub_two[PW-1:0];
        end
        else if (!sub_one[PW])
        begin
            digit    = 2'd1;
            part_rem = sub_one[PW-1:0];
        end
        else
        begin
            digit    = 2'd0;
            part_rem = part;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (s_fire && (s_axis_tuser == pli_pkg::OP_QUERY))
                begin
                    state_next = pli_pkg::ST_RD_FIRST;
                end
            end
            pli_pkg::ST_RD_FIRST:
            begin
                state_next = q_le_rd ? pli_pkg::ST_DONE : pli_pkg::ST_RD_LAST;
            end
            pli_pkg::ST_RD_LAST:
            begin
                state_next = q_ge_rd ? pli_pkg::ST_DONE : pli_pkg::ST_SEARCH;
            end
            pli_pkg::ST_SEARCH:
            begin
                if (q_le_rd)
                begin
                    state_next = pli_pkg::ST_MULDIV;
                end
            end
            pli_pkg::ST_MULDIV:
            begin
                if (step_reg == SW'(1))
                begin
                    state_next = pli_pkg::ST_SUM;
                end
            end
            pli_pkg::ST_SUM:
            begin
                state_next = pli_pkg::ST_DONE;
            end
            pli_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        qx_next        = qx_reg;
        idx_next       = idx_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        den_next       = den_reg;
        dx_next        = dx_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        kind_next      = kind_reg;
        out_y_next     = out_y_reg;
        out_kind_next  = out_kind_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        tbl_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                // read slot 0 while the query is taken
                tbl_raddr = '0;
                qx_next   = in_x;
            end
            pli_pkg::ST_RD_FIRST:
            begin
                tbl_raddr = last_idx;
                px_next   = rd_x;
                py_next   = rd_y;
                res_next  = rd_y;
                kind_next = pli_pkg::KIND_FIRST;
                idx_next  = (AW+1)'(1);
            end
            pli_pkg::ST_RD_LAST:
            begin
                res_next  = rd_y;
                kind_next = pli_pkg::KIND_LAST;
                idx_next  = idx_reg + (AW+1)'(1);
            end
            pli_pkg::ST_SEARCH:
            begin
                if (q_le_rd)
                begin
                    den_next  = seg_den;
                    dx_next   = seg_dx;
                    neg_next  = seg_neg;
                    mag_next  = seg_neg ? seg_down : seg_up;
                    rem_next  = '0;
                    quo_next  = '0;
                    step_next = SW'(pli_pkg::MULDIV_STEPS);
                    kind_next = pli_pkg::KIND_INTERP;
                end
                else
                begin
                    // advance: this entry becomes the lower end
                    px_next  = rd_x;
                    py_next  = rd_y;
                    idx_next = idx_reg + (AW+1)'(1);
                end
            end
            pli_pkg::ST_MULDIV:
            begin
                rem_next  = part_rem[DW-1:0];
                quo_next  = {quo_reg[DW-2:0], 1'b0} + {{(DW-2){1'b0}}, digit};
                mag_next  = {mag_reg[DW-2:0], 1'b0};
                step_next = step_reg - SW'(1);
            end
            pli_pkg::ST_SUM:
            begin
                res_next = neg_reg ? (py_reg - quo_reg[CW-1:0])
                                   : (py_reg + quo_reg[CW-1:0]);
            end
            pli_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_y_next     = res_reg;
                    out_kind_next  = kind_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pli_pkg::ST_IDLE;
            pc_reg        <= pli_pkg::POINT_COUNT_RESET;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        idx_reg      <= idx_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        den_reg      <= den_next;
        dx_reg       <= dx_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        res_reg      <= res_next;
        kind_reg     <= kind_next;
        out_y_reg    <= out_y_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pli_pkg::M_TDATA_W'(out_y_reg);
    assign m_axis_tuser  = out_kind_reg;

endmodule

[rtl/pli_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone: no package dependency.
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
